FILE: rtl/rc4d_pkg.sv
`timescale 1ns / 1ps

package rc4d_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int DROP_W     = 12;

  localparam logic [DROP_W-1:0] DROP_RESET = 12'd1024;

  // Input word kinds.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_INIT = 7'b0000010,
    ST_P0   = 7'b0000100,
    ST_P1   = 7'b0001000,
    ST_P2   = 7'b0010000,
    ST_P3   = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    MODE_DATA = 3'b001,
    MODE_KSA  = 3'b010,
    MODE_DROP = 3'b100
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_wr;    // store a key word
    logic cap_item;  // capture a data word
    logic ksa_init;  // permutation to identity, i = 255, j = 0
    logic rd_a;      // read perm[i + 1]
    logic rd_b;      // read perm[j_next]
    logic rd_t;      // write perm[a], read perm[si + sj]
    logic wr_b;      // write perm[b], advance i and j
    logic ksa;       // key schedule step (adds key byte)
    logic ksa_end;   // clear i and j, load the drop counter
    logic drop_dec;  // one discarded keystream byte done
    logic key_clr;   // clear the key count
    logic out_now;   // load result from the live keystream byte
    logic ks_save;   // hold the keystream byte for later
    logic out_emit;  // load result from the held keystream byte
  } cmd_t;

  typedef struct packed {
    logic a_max;
    logic drop_zero;
    logic drop_one;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/rc4_drop_keystream_cipher_unit.sv
`timescale 1ns / 1ps

// RC4 cipher with an initial keystream drop. Key words (op = 0) are stored,
// up to KEY_MAX of them, and go in back to back; the key word flagged last
// starts the key schedule and the drop, during which in_stall stays high.
// Each data word (op = 1) is XORed with the next keystream byte and comes out
// as one result word with its last flag; the next word can be taken once
// the result is loaded, even while that result waits on out_stall, but not
// while it waits behind a stalled one. Every permutation step (key schedule,
// discarded byte or data byte) is a read of perm[i], a read of perm[j], and
// the swap written back, paced by the single write port and registered read
// port of the 256-entry permutation memory. drop_count resets to 1024;
// the user must write it only while the block is idle; nothing enforces it.
module rc4_drop_keystream_cipher_unit #(
  parameter int KEY_MAX = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [rc4d_pkg::BYTE_W-1:0]   in_value,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rc4d_pkg::BYTE_W-1:0]   out_data_out,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [rc4d_pkg::DROP_W-1:0]   cfg_wr_data
);

  import rc4d_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rc4d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_last  (in_last),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  rc4d_dp #(
    .KEY_MAX (KEY_MAX)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (in_value),
    .in_last      (in_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

endmodule

FILE: rtl/rc4d_ctrl.sv
`timescale 1ns / 1ps

module rc4d_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_op,
  input  logic            in_last,
  output logic            in_stall,
  output rc4d_pkg::cmd_t  cmd,
  input  rc4d_pkg::sts_t  sts
);

  import rc4d_pkg::*;

  state_t state_r, state_nxt;
  mode_t  mode_r,  mode_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_DATA;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    cmd.ksa   = (mode_r == MODE_KSA);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_DATA) begin
            // The first read of the swap goes out with the accept.
            cmd.cap_item = 1'b1;
            cmd.rd_a     = 1'b1;
            mode_nxt     = MODE_DATA;
            state_nxt    = ST_P1;
          end else begin
            cmd.key_wr = 1'b1;
            if (in_last) begin
              state_nxt = ST_INIT;
            end
          end
        end
      end
      ST_INIT: begin
        cmd.ksa_init = 1'b1;
        mode_nxt     = MODE_KSA;
        state_nxt    = ST_P0;
      end
      ST_P0: begin
        cmd.rd_a  = 1'b1;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        cmd.rd_b  = 1'b1;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        cmd.rd_t  = 1'b1;
        state_nxt = ST_P3;
      end
      ST_P3: begin
        cmd.wr_b = 1'b1;
        case (mode_r)
          MODE_KSA: begin
            if (sts.a_max) begin
              cmd.ksa_end = 1'b1;
              if (sts.drop_zero) begin
                cmd.key_clr = 1'b1;
                state_nxt   = ST_IDLE;
              end else begin
                mode_nxt  = MODE_DROP;
                state_nxt = ST_P0;
              end
            end else begin
              state_nxt = ST_P0;
            end
          end
          MODE_DROP: begin
            cmd.drop_dec = 1'b1;
            if (sts.drop_one) begin
              cmd.key_clr = 1'b1;
              state_nxt   = ST_IDLE;
            end else begin
              state_nxt = ST_P0;
            end
          end
          MODE_DATA: begin
            if (sts.out_free) begin
              cmd.out_now = 1'b1;
              state_nxt   = ST_IDLE;
            end else begin
              cmd.ks_save = 1'b1;
              state_nxt   = ST_EMIT;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_emit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rc4d_dp.sv
`timescale 1ns / 1ps

module rc4d_dp #(
  parameter int KEY_MAX = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rc4d_pkg::cmd_t                cmd,
  output rc4d_pkg::sts_t                sts,
  input  logic [rc4d_pkg::BYTE_W-1:0]   in_value,
  input  logic                          in_last,
  input  logic                          cfg_wr_en,
  input  logic [rc4d_pkg::DROP_W-1:0]   cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rc4d_pkg::BYTE_W-1:0]   out_data_out,
  output logic                          out_last
);

  import rc4d_pkg::*;

  localparam int KIW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KCW = $clog2(KEY_MAX + 1);

  // Permutation memory; an entry not written since the last clear reads as its index.
  logic [BYTE_W-1:0]     perm_mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] perm_vld_r;
  logic [BYTE_W-1:0]     prd_r;
  logic [BYTE_W-1:0]     prd_addr_r;
  logic                  prd_vld_r;
  logic [BYTE_W-1:0]     rd_val;
  logic [BYTE_W-1:0]     raddr;
  logic                  rd_en;
  logic [BYTE_W-1:0]     waddr;
  logic [BYTE_W-1:0]     wdata;
  logic                  wr_en;

  logic [BYTE_W-1:0] i_r, j_r, b_r, si_r, sj_r;
  logic [BYTE_W-1:0] a, b_sum, t_sum, ks;

  logic [BYTE_W-1:0] key_mem [KEY_MAX];
  logic [BYTE_W-1:0] key_rd_r;
  logic [KCW-1:0]    key_count_r;
  logic [KCW-1:0]    key_len;
  logic [KIW-1:0]    kidx_r;
  logic              kidx_last;
  logic              key_room;

  logic [DROP_W-1:0] drop_count_r;
  logic [DROP_W-1:0] drop_cnt_r;

  logic [BYTE_W-1:0] value_r;
  logic              last_r;
  logic [BYTE_W-1:0] ks_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;

  assign rd_val = prd_vld_r ? prd_r : prd_addr_r;
  assign a      = i_r + 8'd1;
  assign b_sum  = j_r + rd_val + (cmd.ksa ? key_rd_r : 8'd0);
  assign t_sum  = si_r + rd_val;

  always_comb begin
    if (cmd.rd_b) begin
      raddr = b_sum;
    end else if (cmd.rd_t) begin
      raddr = t_sum;
    end else begin
      raddr = a;
    end
  end

  assign rd_en = cmd.rd_a || cmd.rd_b || cmd.rd_t;
  assign wr_en = cmd.rd_t || cmd.wr_b;
  assign waddr = cmd.rd_t ? a : b_r;
  assign wdata = cmd.rd_t ? rd_val : si_r;

  // The read of perm[si + sj] sees the memory before the swap lands, so both
  // swapped entries are forwarded from the held values.
  always_comb begin
    if (prd_addr_r == b_r) begin
      ks = si_r;
    end else if (prd_addr_r == a) begin
      ks = sj_r;
    end else begin
      ks = rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      prd_r <= perm_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ksa_init) begin
      perm_vld_r <= '0;
    end else if (wr_en) begin
      perm_vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      prd_vld_r  <= perm_vld_r[raddr];
      prd_addr_r <= raddr;
    end
    if (cmd.rd_b) begin
      si_r <= rd_val;
      b_r  <= b_sum;
    end
    if (cmd.rd_t) begin
      sj_r <= rd_val;
    end
    if (cmd.rd_a) begin
      key_rd_r <= key_mem[kidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.ksa_init) begin
      i_r <= 8'hFF;
      j_r <= '0;
    end else if (cmd.ksa_end) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.wr_b) begin
      i_r <= a;
      j_r <= b_r;
    end
  end

  // Key store and the key index that wraps at the stored length.
  assign key_room  = (key_count_r < KCW'(KEY_MAX));
  assign key_len   = (key_count_r == '0) ? KCW'(1) : key_count_r;
  assign kidx_last = ((KCW'(kidx_r) + KCW'(1)) == key_len);

  always_ff @(posedge clk) begin
    if (cmd.key_wr && key_room) begin
      key_mem[key_count_r[KIW-1:0]] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.key_clr) begin
      key_count_r <= '0;
    end else if (cmd.key_wr && key_room) begin
      key_count_r <= key_count_r + KCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ksa_init) begin
      kidx_r <= '0;
    end else if (cmd.wr_b && cmd.ksa) begin
      kidx_r <= kidx_last ? '0 : kidx_r + KIW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_count_r <= DROP_RESET;
      drop_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        drop_count_r <= cfg_wr_data;
      end
      if (cmd.ksa_end) begin
        drop_cnt_r <= drop_count_r;
      end else if (cmd.drop_dec) begin
        drop_cnt_r <= drop_cnt_r - DROP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      value_r <= in_value;
      last_r  <= in_last;
    end
    if (cmd.ks_save) begin
      ks_r <= ks;
    end
    if (cmd.out_now) begin
      out_data_r <= value_r ^ ks;
      out_last_r <= last_r;
    end else if (cmd.out_emit) begin
      out_data_r <= value_r ^ ks_r;
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_now || cmd.out_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

  assign sts.a_max     = (a == 8'hFF);
  assign sts.drop_zero = (drop_count_r == '0);
  assign sts.drop_one  = (drop_cnt_r == DROP_W'(1));
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

FILE: rtl/rc4d_checker.sv
`timescale 1ns / 1ps

module rc4d_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_op,
  input logic [rc4d_pkg::BYTE_W-1:0] in_value,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rc4d_pkg::BYTE_W-1:0] out_data_out,
  input logic                        out_last
);

  import rc4d_pkg::*;

  logic key_mid;
  logic key_end;

  assign key_mid = in_valid && !in_stall && (in_op == OP_KEY) && !in_last;
  assign key_end = in_valid && !in_stall && (in_op == OP_KEY) && in_last;

  // A stalled result word stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data_out) && $stable(out_last))
    else $error("stalled result word changed");

  // A key word that is not the last one does not stall the input that follows it.
  a_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
    key_mid |=> !in_stall)
    else $error("input stalled after a plain key word");

  // The last key word starts the schedule, which blocks the input.
  a_key_sched: assert property (@(posedge clk) disable iff (!rst_n)
    key_end |=> in_stall ##1 in_stall)
    else $error("key schedule did not hold off input");

endmodule

bind rc4_drop_keystream_cipher_unit rc4d_checker u_rc4d_checker (.*);

FILE: dv/rc4_drop_keystream_cipher_unit_chk.sv
`timescale 1ns / 1ps

module rc4_drop_keystream_cipher_unit_chk #(
  parameter int KEY_MAX = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_op,
  input  logic [rc4d_pkg::BYTE_W-1:0]   in_value,
  input  logic                          in_last,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [rc4d_pkg::BYTE_W-1:0]   out_data_out,
  input  logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [rc4d_pkg::DROP_W-1:0]   cfg_wr_data,
  output int                            fail_count,
  output int                            pending_count
);
  import rc4d_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } cipher_word_t;

  logic [BYTE_W-1:0] perm [PERM_DEPTH];
  logic [BYTE_W-1:0] key_bytes [PERM_DEPTH];
  logic [BYTE_W-1:0] ptr_i;
  logic [BYTE_W-1:0] ptr_j;
  int unsigned       key_len;
  logic [DROP_W-1:0] drop_len;
  cipher_word_t      expected_words [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  function automatic void swap_entries(input logic [BYTE_W-1:0] a,
                                       input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] held;
    held    = perm[a];
    perm[a] = perm[b];
    perm[b] = held;
  endfunction

  function automatic logic [BYTE_W-1:0] next_key_byte();
    logic [BYTE_W-1:0] sum;
    ptr_i = ptr_i + BYTE_W'(1);
    ptr_j = ptr_j + perm[ptr_i];
    swap_entries(ptr_i, ptr_j);
    sum = perm[ptr_i] + perm[ptr_j];
    return perm[sum];
  endfunction

  // Full rekey: identity, key schedule over the stored bytes, then the drop.
  function automatic void expand_key();
    int unsigned       len;
    logic [BYTE_W-1:0] acc;
    len = (key_len == 0) ? 1 : key_len;
    for (int k = 0; k < PERM_DEPTH; k++) perm[k[BYTE_W-1:0]] = k[BYTE_W-1:0];
    acc = '0;
    for (int k = 0; k < PERM_DEPTH; k++) begin
      acc = acc + perm[k[BYTE_W-1:0]] + key_bytes[BYTE_W'(k % len)];
      swap_entries(k[BYTE_W-1:0], acc);
    end
    ptr_i = '0;
    ptr_j = '0;
    repeat (drop_len) void'(next_key_byte());
    key_len = 0;
  endfunction

  always @(posedge clk) begin : track
    cipher_word_t want;
    if (!rst_n) begin
      for (int k = 0; k < PERM_DEPTH; k++) perm[k[BYTE_W-1:0]] = k[BYTE_W-1:0];
      ptr_i    = '0;
      ptr_j    = '0;
      key_len  = 0;
      drop_len = DROP_RESET;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) drop_len = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (in_op == OP_KEY) begin
          // Key bytes past the store size are dropped, but their last flag still counts.
          if (key_len < KEY_MAX && key_len < PERM_DEPTH) begin
            key_bytes[key_len[BYTE_W-1:0]] = in_value;
            key_len++;
          end
          if (in_last) expand_key();
        end else begin
          want.data = in_value ^ next_key_byte();
          want.last = in_last;
          expected_words.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, got data_out=%02h out_last=%0b",
                   $time, out_data_out, out_last);
        end else begin
          want = expected_words.pop_front();
          if (out_data_out !== want.data) begin
            mismatches++;
            $display("%0t: data_out expected %02h, got %02h", $time, want.data, out_data_out);
          end
          if (out_last !== want.last) begin
            mismatches++;
            $display("%0t: out_last expected %0b, got %0b", $time, want.last, out_last);
          end
        end
      end
    end
    pending_count <= expected_words.size();
  end

endmodule

FILE: dv/rc4_drop_keystream_cipher_unit_tb.sv
`timescale 1ns / 1ps

module rc4_drop_keystream_cipher_unit_tb;
  import rc4d_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int KEY_MAX        = 256;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_KEY;
  logic [BYTE_W-1:0] in_value = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_data_out;
  logic              out_last;
  logic              cfg_wr_en = 1'b0;
  logic [DROP_W-1:0] cfg_wr_data = '0;

  int                fail_count;
  int                pending;
  int unsigned       idle_cycles = 0;
  int unsigned       words_sent = 0;
  int unsigned       drop_now = 32'(DROP_RESET);
  logic              steady = 1'b0;

  rc4_drop_keystream_cipher_unit #(
    .KEY_MAX (KEY_MAX)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  rc4_drop_keystream_cipher_unit_chk #(
    .KEY_MAX (KEY_MAX)
  ) i_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_out  (out_data_out),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_count (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 37);
  end

  // A key schedule with the largest drop keeps both channels quiet, and a
  // register write may follow a pause as long as that schedule.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic op, input logic [BYTE_W-1:0] value, input logic last);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // A key of the given length, now and then with a data word slipped in.
  task automatic send_key(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(99) < 5) begin
        send_word(OP_DATA, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
      send_word(OP_KEY, BYTE_W'($urandom_range(255)), k == len - 1);
    end
  endtask

  task automatic send_data_run(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      send_word(OP_DATA, BYTE_W'($urandom_range(255)), k == len - 1);
    end
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 75) begin
      len = $urandom_range(99);
      if (len < 75) len = $urandom_range(1, 16);
      else if (len < 95) len = $urandom_range(17, 64);
      else if (len < 98) len = PERM_DEPTH;
      else len = $urandom_range(PERM_DEPTH + 1, PERM_DEPTH + 24);
      send_key(len);
      send_data_run($urandom_range(1, 24));
    end else if (pick < 85) begin
      send_data_run($urandom_range(1, 24));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_word(1'($urandom_range(1)), BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) random_sequence();
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The block may still be scheduling after a final key word, so wait that out.
  task automatic set_drop(input logic [DROP_W-1:0] value);
    wait_results();
    repeat (1100 + 4 * drop_now) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    drop_now = 32'(value);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Data before any key runs on the identity permutation.
    send_word(OP_DATA, 8'h00, 1'b0);
    send_word(OP_DATA, 8'hFF, 1'b1);
    send_word(OP_DATA, 8'h5A, 1'b0);
    send_word(OP_KEY, 8'hFF, 1'b1);
    send_word(OP_DATA, 8'h00, 1'b0);
    send_word(OP_DATA, 8'hFF, 1'b1);
    send_word(OP_KEY, 8'h00, 1'b0);
    send_word(OP_DATA, 8'hA5, 1'b1);
    send_word(OP_KEY, 8'h01, 1'b0);
    send_word(OP_KEY, 8'h80, 1'b1);
    send_word(OP_DATA, 8'h3C, 1'b0);
    send_word(OP_DATA, 8'hC3, 1'b0);
    send_word(OP_DATA, 8'h0F, 1'b0);
    send_word(OP_DATA, 8'hF0, 1'b1);
    send_word(OP_KEY, 8'h00, 1'b1);
    send_word(OP_DATA, 8'h81, 1'b1);
    run_phase(120);

    set_drop('0);
    run_phase(150);

    set_drop({DROP_W{1'b1}});
    run_phase(50);

    // No idling on either side here. The overlong key ends with its last flag
    // on a word that is no longer stored.
    set_drop(12'd1);
    steady = 1'b1;
    send_key(PERM_DEPTH + 44);
    send_data_run(16);
    run_phase(150);
    steady = 1'b0;

    set_drop(DROP_W'($urandom_range(2, 300)));
    run_phase(150);

    set_drop(DROP_RESET);
    run_phase(120);

    wait_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rc4d_pkg.sv
rtl/rc4d_ctrl.sv
rtl/rc4d_dp.sv
rtl/rc4_drop_keystream_cipher_unit.sv
rtl/rc4d_checker.sv
dv/rc4_drop_keystream_cipher_unit_chk.sv
dv/rc4_drop_keystream_cipher_unit_tb.sv
